[rtl/hpid_pkg.sv]
// ----------------------------------------------------------------------------
// hpid_pkg
// Shared types, register map and helpers for the heading PID controller.
// ----------------------------------------------------------------------------
package hpid_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // headings in 1/64 degree
    localparam logic signed [15:0] HALF_TURN = 16'sd11520;
    localparam logic signed [15:0] FULL_TURN = 16'sd23040;

    localparam logic [15:0]        RST_GAIN_P   = 16'd256;
    localparam logic [15:0]        RST_GAIN_I   = 16'd0;
    localparam logic [15:0]        RST_GAIN_D   = 16'd0;
    localparam logic signed [15:0] RST_LIM_LOW  = -16'sd11520;
    localparam logic [14:0]        RST_LIM_HIGH = 15'd11520;
    localparam logic [15:0]        RST_FAST     = 16'd32768;
    localparam logic [15:0]        RST_SLOW     = 16'd8192;
    localparam logic [19:0]        RST_SLOW_DST = 20'd160;

    typedef enum logic [2:0] {
        REG_GAIN_P     = 3'd0,
        REG_GAIN_I     = 3'd1,
        REG_GAIN_D     = 3'd2,
        REG_LIMIT_LOW  = 3'd3,
        REG_LIMIT_HIGH = 3'd4,
        REG_SPEED_FAR  = 3'd5,
        REG_SPEED_NEAR = 3'd6,
        REG_SLOW_DIST  = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [15:0]        gain_p;
        logic [15:0]        gain_i;
        logic [15:0]        gain_d;
        logic signed [15:0] limit_low;
        logic [14:0]        limit_high;
        logic [15:0]        speed_far;
        logic [15:0]        speed_near;
        logic [19:0]        slow_distance;
    } t_cfg;

    typedef struct packed {
        logic [14:0] heading_now;
        logic [14:0] target_course;
        logic [19:0] distance_left;
    } t_in_beat;

    typedef struct packed {
        logic [15:0]        throttle;
        logic signed [15:0] steer;
    } t_out_beat;

    // below low wins over above high when the limits are crossed
    function automatic logic signed [15:0] sat_limits(
        input logic signed [26:0] v,
        input logic signed [15:0] lo,
        input logic [14:0]        hi
    );
        logic signed [26:0] lo_x;
        logic signed [26:0] hi_x;
        lo_x = 27'(lo);
        hi_x = $signed({12'd0, hi});
        if (v < lo_x) begin
            sat_limits = lo;
        end else if (v > hi_x) begin
            sat_limits = $signed({1'b0, hi});
        end else begin
            sat_limits = v[15:0];
        end
    endfunction

endpackage

[rtl/hpid_regs.sv]
// ----------------------------------------------------------------------------
// hpid_regs
// APB register file holding gains, limits, speeds and the slow distance.
// ----------------------------------------------------------------------------
module hpid_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [hpid_pkg::ADDR_W-1:0] paddr,
    input  logic [hpid_pkg::DATA_W-1:0] pwdata,
    output logic [hpid_pkg::DATA_W-1:0] prdata,
    output hpid_pkg::t_cfg             o_cfg
);

    hpid_pkg::t_cfg   r_cfg;
    hpid_pkg::t_cfg   n_cfg;
    hpid_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign w_idx = hpid_pkg::t_reg_idx'(paddr[4:2]);
    assign w_wr  = psel && penable && pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_idx)
                hpid_pkg::REG_GAIN_P:     n_cfg.gain_p        = pwdata[15:0];
                hpid_pkg::REG_GAIN_I:     n_cfg.gain_i        = pwdata[15:0];
                hpid_pkg::REG_GAIN_D:     n_cfg.gain_d        = pwdata[15:0];
                hpid_pkg::REG_LIMIT_LOW:  n_cfg.limit_low     = $signed(pwdata[15:0]);
                hpid_pkg::REG_LIMIT_HIGH: n_cfg.limit_high    = pwdata[14:0];
                hpid_pkg::REG_SPEED_FAR:  n_cfg.speed_far     = pwdata[15:0];
                hpid_pkg::REG_SPEED_NEAR: n_cfg.speed_near    = pwdata[15:0];
                hpid_pkg::REG_SLOW_DIST:  n_cfg.slow_distance = pwdata[19:0];
                default:                  n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p        <= hpid_pkg::RST_GAIN_P;
            r_cfg.gain_i        <= hpid_pkg::RST_GAIN_I;
            r_cfg.gain_d        <= hpid_pkg::RST_GAIN_D;
            r_cfg.limit_low     <= hpid_pkg::RST_LIM_LOW;
            r_cfg.limit_high    <= hpid_pkg::RST_LIM_HIGH;
            r_cfg.speed_far     <= hpid_pkg::RST_FAST;
            r_cfg.speed_near    <= hpid_pkg::RST_SLOW;
            r_cfg.slow_distance <= hpid_pkg::RST_SLOW_DST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (w_idx)
            hpid_pkg::REG_GAIN_P:     prdata = {16'd0, r_cfg.gain_p};
            hpid_pkg::REG_GAIN_I:     prdata = {16'd0, r_cfg.gain_i};
            hpid_pkg::REG_GAIN_D:     prdata = {16'd0, r_cfg.gain_d};
            hpid_pkg::REG_LIMIT_LOW:  prdata = {16'd0, r_cfg.limit_low};
            hpid_pkg::REG_LIMIT_HIGH: prdata = {17'd0, r_cfg.limit_high};
            hpid_pkg::REG_SPEED_FAR:  prdata = {16'd0, r_cfg.speed_far};
            hpid_pkg::REG_SPEED_NEAR: prdata = {16'd0, r_cfg.speed_near};
            hpid_pkg::REG_SLOW_DIST:  prdata = {12'd0, r_cfg.slow_distance};
            default:                  prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/hpid_calc.sv]
// ----------------------------------------------------------------------------
// hpid_calc
// One pass of the controller: throttle select, wrapped heading error,
// saturating integrator and the P+I+D sum with output saturation.
// ----------------------------------------------------------------------------
module hpid_calc (
    input  hpid_pkg::t_cfg      i_cfg,
    input  hpid_pkg::t_in_beat  i_beat,
    input  logic signed [16:0]  i_integ,
    input  logic signed [14:0]  i_prev_err,
    output logic signed [16:0]  o_integ,
    output logic signed [14:0]  o_err,
    output hpid_pkg::t_out_beat o_beat
);

    logic signed [15:0] w_diff;
    logic signed [15:0] w_wrap;
    logic signed [14:0] w_err;
    logic signed [17:0] w_isum;
    logic signed [16:0] w_integ;
    logic signed [15:0] w_derr;
    logic signed [31:0] w_prod_p;
    logic signed [33:0] w_prod_i;
    logic signed [32:0] w_prod_d;
    logic signed [34:0] w_sum;
    logic signed [26:0] w_shift;

    assign w_diff = $signed({1'b0, i_beat.target_course})
                  - $signed({1'b0, i_beat.heading_now});

    always_comb begin
        if (w_diff < -hpid_pkg::HALF_TURN) begin
            w_wrap = w_diff + hpid_pkg::FULL_TURN;
        end else if (w_diff > hpid_pkg::HALF_TURN) begin
            w_wrap = w_diff - hpid_pkg::FULL_TURN;
        end else begin
            w_wrap = w_diff;
        end
    end

    // wrapped error always lies within a half turn
    assign w_err  = $signed(w_wrap[14:0]);
    assign w_isum = 18'(i_integ) + 18'(w_err);
    assign w_integ = 17'(hpid_pkg::sat_limits(27'(w_isum), i_cfg.limit_low,
                                               i_cfg.limit_high));
    assign w_derr = 16'(w_err) - 16'(i_prev_err);

    assign w_prod_p = 32'($signed({1'b0, i_cfg.gain_p})) * 32'(w_err);
    assign w_prod_i = 34'($signed({1'b0, i_cfg.gain_i})) * 34'(w_integ);
    assign w_prod_d = 33'($signed({1'b0, i_cfg.gain_d})) * 33'(w_derr);

    assign w_sum   = 35'(w_prod_p) + 35'(w_prod_i) + 35'(w_prod_d);
    assign w_shift = $signed(w_sum[34:8]);

    assign o_integ         = w_integ;
    assign o_err           = w_err;
    assign o_beat.throttle = (i_beat.distance_left < i_cfg.slow_distance)
                           ? i_cfg.speed_near : i_cfg.speed_far;
    assign o_beat.steer    = hpid_pkg::sat_limits(w_shift, i_cfg.limit_low,
                                                  i_cfg.limit_high);

endmodule

[rtl/heading_pid_controller_core.sv]
// ----------------------------------------------------------------------------
// heading_pid_controller_core
// Steering PID for a compass-course rover with angle wrap and throttle select.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) carries one beat per
// control sample: current heading, target course, distance to go.
// Output channel (o_out_valid / i_out_ready / o_out_data) returns one beat
// per input beat: throttle and saturated steering value, in input order.
// An input register and a result register frame one pass of logic holding
// three multipliers of a 17-bit signed gain by the error, integrator and
// error difference, so a beat is accepted every cycle while results are taken.
// The integrator and previous error update as a beat moves into the result
// register, so a stalled receiver holds all state; one further beat waits
// in the input register, then o_in_ready drops until the result is taken.
// Synchronous reset clears both stages, the integrator and previous error,
// and loads the register defaults; the APB port is always ready.
// ----------------------------------------------------------------------------
module heading_pid_controller_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  hpid_pkg::t_in_beat          i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output hpid_pkg::t_out_beat         o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hpid_pkg::ADDR_W-1:0] paddr,
    input  logic [hpid_pkg::DATA_W-1:0] pwdata,
    output logic [hpid_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    hpid_pkg::t_cfg      w_cfg;
    logic                r_in_vld;
    hpid_pkg::t_in_beat  r_in;
    logic                r_out_vld;
    hpid_pkg::t_out_beat r_out;
    logic signed [16:0]  r_integ;
    logic signed [14:0]  r_prev_err;
    logic signed [16:0]  w_integ;
    logic signed [14:0]  w_err;
    hpid_pkg::t_out_beat w_beat;
    logic                w_adv;
    logic                w_take;

    hpid_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (w_cfg)
    );

    hpid_calc u_calc (
        .i_cfg      (w_cfg),
        .i_beat     (r_in),
        .i_integ    (r_integ),
        .i_prev_err (r_prev_err),
        .o_integ    (w_integ),
        .o_err      (w_err),
        .o_beat     (w_beat)
    );

    assign pready     = 1'b1;
    assign w_adv      = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || w_adv;
    assign w_take     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_integ    <= '0;
            r_prev_err <= '0;
        end else begin
            if (w_take) begin
                r_in_vld <= 1'b1;
            end else if (w_adv) begin
                r_in_vld <= 1'b0;
            end
            if (w_adv) begin
                r_out_vld  <= 1'b1;
                r_integ    <= w_integ;
                r_prev_err <= w_err;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in <= i_in_data;
        end
        if (w_adv) begin
            r_out <= w_beat;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_prev_err >= -hpid_pkg::HALF_TURN) && (r_prev_err <= hpid_pkg::HALF_TURN))
        else $error("previous error outside half turn");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_integ) && $stable(r_prev_err))
        else $error("controller state changed without a beat");

    a_adv_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_vld)
        else $error("result register not filled after advance");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_out_vld && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while both stages are full");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_vld |-> o_in_ready)
        else $error("empty input stage not ready");

endmodule
